@@ sv/p2av_pkg.sv @@
`default_nettype none

package p2av_pkg;

    // Table geometry
    localparam int TABLE_KEYS_DEF = 256;
    localparam int ADDR_W         = 10;
    localparam int CHAR_W         = 8;

    // Queue depths between the stages and at the result side
    localparam int CMD_Q_DEPTH = 2;
    localparam int OUT_Q_DEPTH = 4;

    // Configuration register indexes
    localparam logic CFG_KEYPAD_APP = 1'b0;
    localparam logic CFG_SWAP_CAPS  = 1'b1;

    // Keyboard prefix and status bytes
    localparam logic [7:0] SC_EXT      = 8'hE0;
    localparam logic [7:0] SC_REL      = 8'hF0;
    localparam logic [7:0] SC_PAUSE    = 8'hE1;
    localparam logic [7:0] SC_BAT_OK   = 8'hAA;
    localparam logic [7:0] SC_ACK      = 8'hFA;
    localparam logic [7:0] SC_ECHO     = 8'hEE;
    localparam logic [7:0] SC_RESEND   = 8'hFE;
    localparam logic [7:0] SC_ERR_LO   = 8'h00;
    localparam logic [7:0] SC_ERR_HI   = 8'hFF;

    // Key codes with fixed meaning
    localparam logic [7:0] SC_CAPS     = 8'h58;
    localparam logic [7:0] SC_LCTRL    = 8'h14;
    localparam logic [7:0] SC_LSHIFT   = 8'h12;
    localparam logic [7:0] SC_RSHIFT   = 8'h59;
    localparam logic [7:0] SC_LALT     = 8'h11;
    localparam logic [7:0] SC_NUMLOCK  = 8'h77;
    localparam logic [7:0] SC_SCROLL   = 8'h7E;
    localparam logic [7:0] SC_UP       = 8'h75;
    localparam logic [7:0] SC_DOWN     = 8'h72;
    localparam logic [7:0] SC_RIGHT    = 8'h74;
    localparam logic [7:0] SC_LEFT     = 8'h6B;
    localparam logic [7:0] SC_KP_ENTER = 8'h5A;
    localparam logic [7:0] SC_KP_SLASH = 8'h4A;

    // Host characters
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] CH_APP_M    = 8'h4D;
    localparam logic [7:0] CH_APP_P    = 8'h50;
    localparam logic [6:0] CH_LOW_A    = 7'h61;
    localparam logic [6:0] CH_LOW_Z    = 7'h7A;
    localparam logic [6:0] CH_CASE_OFS = 7'h20;

    // Prefix tracker states
    typedef enum logic [3:0] {
        PS_IDLE,
        PS_REL,
        PS_EXT,
        PS_EXT_REL,
        PS_PAUSE0,
        PS_PAUSE1,
        PS_PAUSE2,
        PS_PAUSE3,
        PS_PAUSE4,
        PS_PAUSE5,
        PS_PAUSE6
    } prefix_t;

    // Back end states
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } back_state_t;

    // Work handed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_LOOKUP,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        logic              caps;
        logic [1:0]        cnt;
        logic [7:0]        seq0;
        logic [7:0]        seq1;
        logic [7:0]        seq2;
    } cmd_t;

    // Bytes expected after E1 in the pause sequence
    function automatic logic [7:0] pause_byte(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            3'd0:    v = 8'h14;
            3'd1:    v = 8'h77;
            3'd2:    v = 8'hE1;
            3'd3:    v = 8'hF0;
            3'd4:    v = 8'h14;
            3'd5:    v = 8'hF0;
            3'd6:    v = 8'h77;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/ps2_scan_to_ascii_vt52_top.sv @@
`default_nettype none

// Channel   Ports                                          Transfer when
// -------   ---------------------------------------------  ----------------
// input     push full req_type scan_byte table_addr        push && !full
//           table_data
// result    empty pop host_byte last_byte                  pop && !empty
// config    cfg_wr_en cfg_index cfg_data                   cfg_wr_en
//
// The front decodes one input per cycle while full is low; the back takes a table
// write as it pops the command, a table lookup through a registered memory read
// in B_READ and an escape sequence of n bytes in B_EMIT, one byte per cycle at the
// single result write while the result queue is not full. After reset the table
// is zeroed one entry per cycle, all TABLE_KEYS*4 entries (1024 by default);
// full stays high meanwhile. A stalled result side fills the result queue, then
// the command queue, then raises full.

module ps2_scan_to_ascii_vt52_top
    import p2av_pkg::*;
#(
    parameter int TABLE_KEYS = TABLE_KEYS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              req_type,
    input  wire logic [7:0]        scan_byte,
    input  wire logic [ADDR_W-1:0] table_addr,
    input  wire logic [7:0]        table_data,
    output logic                   empty,
    input  wire logic              pop,
    output logic      [7:0]        host_byte,
    output logic                   last_byte,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic              cfg_data
);

    localparam int CMD_W = $bits(cmd_t);

    logic             item_accept;
    logic             cmd_push;
    cmd_t             cmd_in;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    cmd_t             cmd_out;
    logic             clear_busy;
    logic             out_full;
    logic             out_push;
    logic [7:0]       out_byte;
    logic             out_last;
    logic [8:0]       out_rdata;

    assign full        = clear_busy || cmd_full;
    assign item_accept = push && !full;
    assign cmd_out     = cmd_t'(cmd_rdata);
    assign host_byte   = out_rdata[8:1];
    assign last_byte   = out_rdata[0];

    // Decode and classify
    p2av_front #(
        .TABLE_KEYS(TABLE_KEYS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_accept(item_accept),
        .req_type   (req_type),
        .scan_byte  (scan_byte),
        .table_addr (table_addr),
        .table_data (table_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    // Command queue between front and back
    p2av_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .wdata(cmd_in),
        .full (cmd_full),
        .pop  (cmd_pop),
        .rdata(cmd_rdata),
        .empty(cmd_empty)
    );

    // Table access and byte generation
    p2av_back #(
        .TABLE_KEYS(TABLE_KEYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .clear_busy(clear_busy)
    );

    // Result queue
    p2av_fifo #(
        .WIDTH(9),
        .DEPTH(OUT_Q_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .wdata({out_byte, out_last}),
        .full (out_full),
        .pop  (pop),
        .rdata(out_rdata),
        .empty(empty)
    );

endmodule

`default_nettype wire

@@ sv/p2av_fifo.sv @@
`default_nettype none

module p2av_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Fill level tracks the pointer distance
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != CW'(DEPTH)) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("fifo pointers collide while partly filled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo fill level out of range");

endmodule

`default_nettype wire

@@ sv/p2av_front.sv @@
`default_nettype none

module p2av_front
    import p2av_pkg::*;
#(
    parameter int TABLE_KEYS = TABLE_KEYS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_accept,
    input  wire logic              req_type,
    input  wire logic [7:0]        scan_byte,
    input  wire logic [ADDR_W-1:0] table_addr,
    input  wire logic [7:0]        table_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic              cfg_data,
    output logic                   cmd_push,
    output cmd_t                   cmd
);

    prefix_t    ps_reg;
    prefix_t    ps_next;
    logic       lshift_reg, lshift_next;
    logic       rshift_reg, rshift_next;
    logic       ctrl_reg, ctrl_next;
    logic       caps_reg, caps_next;
    logic       keypad_app_reg;
    logic       swap_reg;

    logic       plain_go;
    logic       ext_go;
    logic       key_rel;
    logic [7:0] mod_key;
    logic [16:0] kp;
    logic [2:0] pause_idx;

    // Keys that are swallowed as function keys
    function automatic logic is_function_key(input logic [7:0] k);
        logic hit;
        case (k)
            8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B,
            8'h83, 8'h0A, 8'h01, 8'h09, 8'h78, 8'h07: hit = 1'b1;
            default:                                  hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Keypad application sequences: {hit, first, second}; first zero means silent
    function automatic logic [16:0] keypad_seq(input logic [7:0] k);
        logic [16:0] r;
        case (k)
            8'h70:        r = {1'b1, CH_QMARK, 8'h70};
            8'h69:        r = {1'b1, CH_QMARK, 8'h71};
            8'h72:        r = {1'b1, CH_QMARK, 8'h72};
            8'h7A:        r = {1'b1, CH_QMARK, 8'h73};
            8'h6B:        r = {1'b1, CH_QMARK, 8'h74};
            8'h73:        r = {1'b1, CH_QMARK, 8'h75};
            8'h74:        r = {1'b1, CH_QMARK, 8'h76};
            8'h6C:        r = {1'b1, CH_QMARK, 8'h77};
            8'h75:        r = {1'b1, CH_QMARK, 8'h78};
            8'h7D:        r = {1'b1, CH_QMARK, 8'h79};
            8'h71:        r = {1'b1, CH_QMARK, 8'h7A};
            8'h7C:        r = {1'b1, 8'h51, 8'h00};
            8'h7B:        r = {1'b1, 8'h52, 8'h00};
            8'h77, 8'h79: r = {1'b1, 8'h00, 8'h00};
            default:      r = '0;
        endcase
        return r;
    endfunction

    function automatic cmd_t emit_cmd(input logic [1:0] n, input logic [7:0] c0,
                                      input logic [7:0] c1, input logic [7:0] c2);
        cmd_t c;
        c      = '0;
        c.op   = CMD_EMIT;
        c.cnt  = n;
        c.seq0 = c0;
        c.seq1 = c1;
        c.seq2 = c2;
        return c;
    endfunction

    assign pause_idx = 3'(ps_reg - PS_PAUSE0);
    assign mod_key   = (swap_reg && scan_byte == SC_CAPS)  ? SC_LCTRL :
                       (swap_reg && scan_byte == SC_LCTRL) ? SC_CAPS  : scan_byte;
    assign kp        = keypad_seq(scan_byte);

    // Prefix tracker next state
    always_comb
    begin
        ps_next = ps_reg;
        if (item_accept && !req_type)
        begin
            unique case (ps_reg) inside
                PS_IDLE:
                begin
                    case (scan_byte)
                        SC_EXT:   ps_next = PS_EXT;
                        SC_PAUSE: ps_next = PS_PAUSE0;
                        SC_REL:   ps_next = PS_REL;
                        default:  ps_next = PS_IDLE;
                    endcase
                end
                PS_REL, PS_EXT_REL:
                begin
                    ps_next = PS_IDLE;
                end
                PS_EXT:
                begin
                    ps_next = (scan_byte == SC_REL) ? PS_EXT_REL : PS_IDLE;
                end
                [PS_PAUSE0:PS_PAUSE6]:
                begin
                    if (ps_reg != PS_PAUSE6 && scan_byte == pause_byte(pause_idx))
                    begin
                        ps_next = prefix_t'(ps_reg + 4'd1);
                    end
                    else
                    begin
                        ps_next = PS_IDLE;
                    end
                end
                default:
                begin
                    ps_next = PS_IDLE;
                end
            endcase
        end
    end

    // Classification: command for the back end and modifier updates
    always_comb
    begin
        cmd         = '0;
        cmd_push    = 1'b0;
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        ctrl_next   = ctrl_reg;
        caps_next   = caps_reg;
        plain_go    = 1'b0;
        ext_go      = 1'b0;
        key_rel     = 1'b0;

        if (item_accept)
        begin
            if (req_type)
            begin
                if (int'(table_addr) < TABLE_KEYS * 4)
                begin
                    cmd_push  = 1'b1;
                    cmd.op    = CMD_WRITE;
                    cmd.addr  = table_addr;
                    cmd.wdata = table_data;
                end
            end
            else
            begin
                unique case (ps_reg) inside
                    PS_REL:
                    begin
                        plain_go = 1'b1;
                        key_rel  = 1'b1;
                    end
                    PS_EXT:
                    begin
                        ext_go = (scan_byte != SC_REL);
                    end
                    PS_EXT_REL:
                    begin
                        ext_go  = 1'b1;
                        key_rel = 1'b1;
                    end
                    PS_IDLE:
                    begin
                        case (scan_byte) inside
                            SC_BAT_OK:
                            begin
                                cmd_push = 1'b1;
                                cmd      = emit_cmd(2'd1, SC_BAT_OK, 8'h00, 8'h00);
                            end
                            SC_ACK, SC_ECHO, SC_RESEND, SC_ERR_LO, SC_ERR_HI,
                            SC_EXT, SC_PAUSE, SC_REL:
                            begin
                                plain_go = 1'b0;
                            end
                            default:
                            begin
                                plain_go = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        plain_go = 1'b0;
                    end
                endcase
            end
        end

        // Plain (non-extended) key
        if (plain_go)
        begin
            if (scan_byte == SC_NUMLOCK || scan_byte == SC_SCROLL)
            begin
                cmd_push = 1'b0;
            end
            else if (mod_key == SC_LSHIFT)
            begin
                lshift_next = !key_rel;
            end
            else if (mod_key == SC_RSHIFT)
            begin
                rshift_next = !key_rel;
            end
            else if (mod_key == SC_LCTRL)
            begin
                ctrl_next = !key_rel;
            end
            else if (mod_key == SC_CAPS)
            begin
                if (!key_rel)
                begin
                    caps_next = !caps_reg;
                end
            end
            else if (mod_key == SC_LALT || is_function_key(scan_byte))
            begin
                cmd_push = 1'b0;
            end
            else if (keypad_app_reg && kp[16])
            begin
                if (!key_rel && kp[15:8] != 8'h00)
                begin
                    cmd_push = 1'b1;
                    cmd      = emit_cmd((kp[7:0] != 8'h00) ? 2'd3 : 2'd2,
                                        CH_ESC, kp[15:8], kp[7:0]);
                end
            end
            else if (!key_rel && int'(scan_byte) < TABLE_KEYS)
            begin
                cmd_push = 1'b1;
                cmd.op   = CMD_LOOKUP;
                cmd.addr = {scan_byte, ctrl_reg, lshift_reg | rshift_reg};
                cmd.caps = caps_reg;
            end
        end

        // Extended key
        if (ext_go)
        begin
            case (scan_byte)
                SC_UP:
                begin
                    cmd_push = !key_rel;
                    cmd      = emit_cmd(2'd2, CH_ESC, CH_UP, 8'h00);
                end
                SC_DOWN:
                begin
                    cmd_push = !key_rel;
                    cmd      = emit_cmd(2'd2, CH_ESC, CH_DOWN, 8'h00);
                end
                SC_RIGHT:
                begin
                    cmd_push = !key_rel;
                    cmd      = emit_cmd(2'd2, CH_ESC, CH_RIGHT, 8'h00);
                end
                SC_LEFT:
                begin
                    cmd_push = !key_rel;
                    cmd      = emit_cmd(2'd2, CH_ESC, CH_LEFT, 8'h00);
                end
                SC_KP_ENTER:
                begin
                    cmd_push = !key_rel;
                    cmd      = keypad_app_reg ? emit_cmd(2'd3, CH_ESC, CH_QMARK, CH_APP_M)
                                              : emit_cmd(2'd1, CH_CR, 8'h00, 8'h00);
                end
                SC_KP_SLASH:
                begin
                    cmd_push = !key_rel;
                    cmd      = keypad_app_reg ? emit_cmd(2'd2, CH_ESC, CH_APP_P, 8'h00)
                                              : emit_cmd(2'd1, CH_SLASH, 8'h00, 8'h00);
                end
                SC_LCTRL:
                begin
                    // right control acts as caps lock only when swapped
                    if (swap_reg && !key_rel)
                    begin
                        caps_next = !caps_reg;
                    end
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg     <= PS_IDLE;
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
        end
        else
        begin
            ps_reg     <= ps_next;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keypad_app_reg <= 1'b0;
            swap_reg       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_KEYPAD_APP: keypad_app_reg <= cfg_data;
                CFG_SWAP_CAPS:  swap_reg       <= cfg_data;
                default:        swap_reg       <= swap_reg;
            endcase
        end
    end

    // A table write never disturbs prefix tracking
    a_write_keeps_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && req_type) |=> $stable(ps_reg))
        else $error("table write changed prefix state");

    // PS_PAUSE1 is only entered from the previous pause step, PS_PAUSE0
    a_pause_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ps_reg == PS_PAUSE1) |-> ($past(ps_reg) == PS_PAUSE0 || $past(ps_reg) == PS_PAUSE1))
        else $error("pause sequence skipped a step");

endmodule

`default_nettype wire

@@ sv/p2av_back.sv @@
`default_nettype none

module p2av_back
    import p2av_pkg::*;
#(
    parameter int TABLE_KEYS = TABLE_KEYS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_empty,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    input  wire logic       out_full,
    output logic            out_push,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            clear_busy
);

    localparam int TBL_DEPTH = TABLE_KEYS * 4;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic [7:0]        tbl_mem [TBL_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clear_reg;
    logic [TBL_AW-1:0] clear_cnt_reg;

    back_state_t st_reg;
    back_state_t st_next;
    logic        caps_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  pos_reg;
    logic [7:0]  seq_reg [3];

    logic              mem_we;
    logic              mem_re;
    logic [TBL_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [6:0]        low7;
    logic              make_upper;
    logic [7:0]        char_out;

    assign clear_busy = clear_reg;

    // Caps lock upper-cases letters only; bit 7 is dropped
    assign low7       = rd_data_reg[6:0];
    assign make_upper = caps_reg && low7 >= CH_LOW_A && low7 <= CH_LOW_Z;
    assign char_out   = {1'b0, make_upper ? low7 - CH_CASE_OFS : low7};

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE:
            begin
                if (!cmd_empty && !clear_reg)
                begin
                    case (cmd.op)
                        CMD_LOOKUP: st_next = B_READ;
                        CMD_EMIT:   st_next = B_EMIT;
                        default:    st_next = B_IDLE;
                    endcase
                end
            end
            B_READ:
            begin
                if (rd_data_reg == 8'h00 || !out_full)
                begin
                    st_next = B_IDLE;
                end
            end
            B_EMIT:
            begin
                if (!out_full && pos_reg == cnt_reg - 2'd1)
                begin
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    // Outputs and memory controls
    always_comb
    begin
        cmd_pop   = (st_reg == B_IDLE) && !cmd_empty && !clear_reg;
        mem_we    = clear_reg || (cmd_pop && cmd.op == CMD_WRITE);
        mem_re    = cmd_pop && cmd.op == CMD_LOOKUP;
        mem_waddr = clear_reg ? clear_cnt_reg : cmd.addr[TBL_AW-1:0];
        mem_wdata = clear_reg ? 8'h00 : cmd.wdata;
        out_push  = 1'b0;
        out_byte  = 8'h00;
        out_last  = 1'b0;
        unique case (st_reg)
            B_READ:
            begin
                out_push = (rd_data_reg != 8'h00) && !out_full;
                out_byte = char_out;
                out_last = 1'b1;
            end
            B_EMIT:
            begin
                out_push = !out_full;
                out_byte = seq_reg[pos_reg];
                out_last = (pos_reg == cnt_reg - 2'd1);
            end
            default:
            begin
                out_push = 1'b0;
            end
        endcase
    end

    // Control state and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            pos_reg       <= 2'd0;
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cmd_pop)
            begin
                pos_reg <= 2'd0;
            end
            else if (st_reg == B_EMIT && !out_full)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
            if (clear_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == TBL_AW'(TBL_DEPTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
        end
    end

    // Command payload held while the back end works
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            caps_reg   <= cmd.caps;
            cnt_reg    <= cmd.cnt;
            seq_reg[0] <= cmd.seq0;
            seq_reg[1] <= cmd.seq1;
            seq_reg[2] <= cmd.seq2;
        end
    end

    // Translation memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tbl_mem[cmd.addr[TBL_AW-1:0]];
        end
    end

    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_EMIT) |-> (pos_reg < cnt_reg))
        else $error("escape sequence index past its length");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg |=> !clear_reg)
        else $error("table clearing restarted");

endmodule

`default_nettype wire
